[src/hbd_pkg.sv]
// ============================================================================
// Half-band decimator package
// Shared widths, sequencing control type, tap tables and rounding functions
// for the stereo half-band decimator cascade.
// ============================================================================
package hbd_pkg;

   // Filter geometry.
   localparam int HBD_TAPS       = 15;
   localparam int HBD_NZ_TAPS    = 7;
   localparam int HBD_MAX_STAGES = 2;

   // Field and datapath widths.
   localparam int PCM_W    = 16;
   localparam int SAMPLE_W = 26;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int TAP_W    = 3;
   localparam int POS_W    = 4;
   localparam int CFG_W    = 2;

   // Control word from the sequencer to the lanes and the output stage.
   typedef struct packed {
      logic             load_in;
      logic             wr_en;
      logic             rd_en;
      logic [TAP_W-1:0] tap;
      logic             acc_clr;
      logic             load_res;
      logic             out_load;
   } hbd_ctl_type;

   // Delay (in samples) of each nonzero tap, in order of issue.
   function automatic logic [POS_W-1:0] hbd_tap_lag(input logic [TAP_W-1:0] k);
      logic [POS_W-1:0] lag;
      case (k)
         3'd0:    lag = 4'd2;
         3'd1:    lag = 4'd4;
         3'd2:    lag = 4'd6;
         3'd3:    lag = 4'd7;
         3'd4:    lag = 4'd8;
         3'd5:    lag = 4'd10;
         3'd6:    lag = 4'd12;
         default: lag = 4'd0;
      endcase
      return lag;
   endfunction

   // Q1.17 coefficient of each nonzero tap, in order of issue.
   function automatic logic signed [COEF_W-1:0] hbd_coef(input logic [TAP_W-1:0] k);
      logic signed [COEF_W-1:0] c;
      case (k)
         3'd0, 3'd6: c = 18'sd756;
         3'd1, 3'd5: c = -18'sd6386;
         3'd2, 3'd4: c = 18'sd38400;
         3'd3:       c = 18'sd65532;
         default:    c = 18'sd0;
      endcase
      return c;
   endfunction

   // Round a 25-fraction-bit sum half away from zero to 8 fraction bits and
   // saturate it to the 26-bit sample range.
   function automatic logic signed [SAMPLE_W-1:0] hbd_round_stage(
         input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] rnd;
      logic signed [ACC_W-18:0] q;
      logic signed [SAMPLE_W-1:0] res;
      // Negative values take one less than half, which rounds ties away.
      bias = acc[ACC_W-1] ? 45'sd65535 : 45'sd65536;
      rnd  = acc + bias;
      q    = rnd[ACC_W-1:17];
      if (q > 28'sd33554431) begin
         res = 26'sd33554431;
      end else if (q < -28'sd33554432) begin
         res = -26'sd33554432;
      end else begin
         res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // Round an 8-fraction-bit sample half away from zero to an integer and
   // saturate it to the PCM range.
   function automatic logic signed [PCM_W-1:0] hbd_round_pcm(
         input logic signed [SAMPLE_W-1:0] v);
      logic signed [SAMPLE_W:0] bias;
      logic signed [SAMPLE_W:0] rnd;
      logic signed [SAMPLE_W-8:0] q;
      logic signed [PCM_W-1:0] res;
      bias = v[SAMPLE_W-1] ? 27'sd127 : 27'sd128;
      rnd  = {v[SAMPLE_W-1], v} + bias;
      q    = rnd[SAMPLE_W:8];
      if (q > 19'sd32767) begin
         res = 16'sd32767;
      end else if (q < -19'sd32768) begin
         res = -16'sd32768;
      end else begin
         res = q[PCM_W-1:0];
      end
      return res;
   endfunction

endpackage

[src/hbd_ram.sv]
// ============================================================================
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ============================================================================
module hbd_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hbd_lane.sv]
// ============================================================================
// Half-band decimator lane
// One channel: per-stage sample history, multiply-accumulate over the nonzero
// taps and the running sample that moves from stage to stage.
// ============================================================================
module hbd_lane #(
   parameter int DEPTH = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hbd_pkg::hbd_ctl_type                ctl,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   input  logic signed [hbd_pkg::PCM_W-1:0]    in_sample,
   output logic signed [hbd_pkg::SAMPLE_W-1:0] cur_sample
);
   import hbd_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [DEPTH-1:0]           valid_ff;
   logic [SAMPLE_W-1:0]        rd_data;
   logic                       hit_ff;
   logic                       rd_vld_ff;
   logic [TAP_W-1:0]           tap_d_ff;
   logic signed [SAMPLE_W-1:0] tap_sample;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic signed [SAMPLE_W-1:0] cur_in;

   // History store for all stages of this channel.
   hbd_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr[AW-1:0]),
      .wr_data (cur_ff),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // Valid bits stand in for the all-zero history after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         tap_d_ff    <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         hit_ff      <= ctl.rd_en & valid_ff[rd_addr];
         rd_vld_ff   <= ctl.rd_en;
         tap_d_ff    <= ctl.tap;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // Multiply the returned history entry by its coefficient.
   assign tap_sample = hit_ff ? $signed(rd_data) : '0;
   assign prod_in    = tap_sample * hbd_coef(tap_d_ff);

   // Accumulate products, then round into the running sample.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      cur_in = cur_ff;
      if (ctl.load_in) begin
         cur_in = {{(SAMPLE_W - PCM_W - 8){in_sample[PCM_W-1]}}, in_sample, 8'h00};
      end else if (ctl.load_res) begin
         cur_in = hbd_round_stage(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      cur_ff  <= cur_in;
   end

   assign cur_sample = cur_ff;

endmodule

[src/hbd_merge.sv]
// ============================================================================
// Half-band decimator output stage
// Joins both lanes into one stereo result, rounds to PCM and holds it in the
// output register until the receiver takes it.
// ============================================================================
module hbd_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  hbd_pkg::hbd_ctl_type                ctl,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] left_cur,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] right_cur,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata
);
   import hbd_pkg::*;

   logic        valid_ff;
   logic [31:0] data_ff;

   // The register can take a new result when empty or emptying this cycle.
   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Left in the low half, right in the high half.
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         data_ff <= {hbd_round_pcm(right_cur), hbd_round_pcm(left_cur)};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[src/stereo_halfband_decimator_cascade.sv]
// ============================================================================
// Stereo half-band decimator cascade
// Passes stereo PCM frames through zero to MAX_STAGES divide-by-two
// half-band FIR stages, one lane per channel.
// ============================================================================
// Usage:
//  - csr_data sets the number of stages in use (values above MAX_STAGES act
//    as MAX_STAGES). Write it only while no frame is in flight.
//  - req_tdata carries one stereo frame per transfer; rsp_tdata carries one
//    decimated frame. With k stages a result comes out for one input frame
//    in 2^k; other frames only update the filter histories.
//  - A frame that goes on through a stage takes one history write, seven tap
//    reads from the history RAM (one read port per lane), a drain through the
//    multiplier and accumulator, and one rounding step; at a stage where it
//    stops, only the history write happens and the block is freed without
//    running later stages. req_tready is high only while the sequencer is idle.
//  - The output register holds one result; the next frame is accepted while
//    it waits, and only delivery of a further result waits on rsp_tready.
//  - Reset clears the stage count, positions, phases and history valid bits,
//    so every history reads as zero until written.
// ============================================================================
module stereo_halfband_decimator_cascade #(
   parameter int MAX_STAGES = hbd_pkg::HBD_MAX_STAGES
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration: number of stages in use.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [hbd_pkg::CFG_W-1:0] csr_data,
   // Input frames.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,  // [15:0] left_in, [31:16] right_in
   // Result frames.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata   // [15:0] left_out, [31:16] right_out
);
   import hbd_pkg::*;

   localparam int DEPTH = MAX_STAGES * HBD_TAPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int NW    = $clog2(MAX_STAGES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STAGE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [SW-1:0]    stage_ff, stage_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             drain_ff, drain_in;
   logic [POS_W-1:0] pos_ff [MAX_STAGES];
   logic [POS_W-1:0] pos_in [MAX_STAGES];
   logic [MAX_STAGES-1:0] phase_ff, phase_in;

   hbd_ctl_type      ctl;
   logic [NW-1:0]    n_lim;
   logic [POS_W-1:0] pos_cur;
   logic [POS_W-1:0] pos_next;
   logic             stage_last;
   logic [4:0]       lag_diff;
   logic [POS_W-1:0] lag_off;
   logic [AW-1:0]    base_addr;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic             out_free;
   logic signed [SAMPLE_W-1:0] left_cur;
   logic signed [SAMPLE_W-1:0] right_cur;

   // Configuration is always taken.
   assign csr_ready = 1'b1;

   // Stage count limited to the stages built.
   assign n_lim = ({1'b0, cfg_ff} > (CFG_W + 1)'(MAX_STAGES)) ? NW'(MAX_STAGES)
                                                              : NW'(cfg_ff);

   // History addressing for the current stage.
   assign pos_cur    = pos_ff[stage_ff];
   assign pos_next   = (pos_cur == POS_W'(HBD_TAPS - 1)) ? '0 : pos_cur + 1'b1;
   assign stage_last = (NW'(stage_ff) + NW'(1)) == n_ff;
   assign lag_diff   = {1'b0, pos_cur} + 5'(HBD_TAPS) - {1'b0, hbd_tap_lag(tap_ff)};
   assign lag_off    = (lag_diff >= 5'(HBD_TAPS)) ? 4'(lag_diff - 5'(HBD_TAPS))
                                                  : lag_diff[POS_W-1:0];
   assign base_addr  = AW'(stage_ff) * AW'(HBD_TAPS);
   assign wr_addr    = base_addr + AW'(pos_cur);
   assign rd_addr    = base_addr + AW'(lag_off);

   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: walks the frame through the stages in use.
   always_comb begin
      state_in = state_ff;
      cfg_in   = csr_valid ? csr_data : cfg_ff;
      n_in     = n_ff;
      stage_in = stage_ff;
      tap_in   = tap_ff;
      drain_in = drain_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load_in = 1'b1;
               stage_in    = '0;
               n_in        = n_lim;
               state_in    = (n_lim == '0) ? ST_EMIT : ST_STAGE;
            end
         end
         ST_STAGE: begin
            // Store the sample; only every second sample goes on.
            ctl.wr_en          = 1'b1;
            phase_in[stage_ff] = ~phase_ff[stage_ff];
            if (!phase_ff[stage_ff]) begin
               pos_in[stage_ff] = pos_next;
               state_in         = ST_IDLE;
            end else begin
               ctl.acc_clr = 1'b1;
               tap_in      = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.rd_en = 1'b1;
            ctl.tap   = tap_ff;
            tap_in    = tap_ff + 1'b1;
            if (tap_ff == TAP_W'(HBD_NZ_TAPS - 1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for the last product to reach the accumulator.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            ctl.load_res     = 1'b1;
            pos_in[stage_ff] = pos_next;
            if (stage_last) begin
               state_in = ST_EMIT;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = ST_STAGE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff   <= '0;
         n_ff     <= '0;
         stage_ff <= '0;
         tap_ff   <= '0;
         drain_ff <= 1'b0;
         phase_ff <= '0;
         for (int i = 0; i < MAX_STAGES; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
         n_ff     <= n_in;
         stage_ff <= stage_in;
         tap_ff   <= tap_in;
         drain_ff <= drain_in;
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // One lane per channel.
   hbd_lane #(
      .DEPTH(DEPTH)
   ) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .in_sample  ($signed(req_tdata[15:0])),
      .cur_sample (left_cur)
   );

   hbd_lane #(
      .DEPTH(DEPTH)
   ) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .in_sample  ($signed(req_tdata[31:16])),
      .cur_sample (right_cur)
   );

   // Rounding and output register.
   hbd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .left_cur   (left_cur),
      .right_cur  (right_cur),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/sv/tb.sv]
// ============================================================================
// Stereo half-band decimator cascade testbench
// Streams stereo PCM frames through the cascade under zero, one, two and an
// over-range count of stages. A behavioral copy of the filters predicts every
// decimated frame. Random gaps on the input side and random stalls on the
// output side move the handshakes across every phase of the block's work.
// ============================================================================
module tb;
   import hbd_pkg::*;

   // Time the block may still be busy with a frame that gives no result.
   localparam int SETTLE_CYCLES = 2 + 11 * HBD_MAX_STAGES + 16;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_FRAMES  = 75;

   typedef struct packed {
      logic signed [PCM_W-1:0] left;
      logic signed [PCM_W-1:0] right;
   } pcm_pair_type;

   typedef enum logic [1:0] {
      SRC_NOISE,
      SRC_QUIET,
      SRC_TONE,
      SRC_RAILS
   } source_kind_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_data   = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;  // [15:0] left_in, [31:16] right_in
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // [15:0] left_out, [31:16] right_out

   // Expected decimated frames, oldest first.
   pcm_pair_type decimated_q[$];
   int        error_count = 0;
   bit        idle_on     = 1'b1;

   // Filter state of the behavioral copy; channel 0 is left, 1 is right.
   logic signed [SAMPLE_W-1:0] tap_line [2][HBD_MAX_STAGES][HBD_TAPS];
   logic [POS_W-1:0]           head_pos [HBD_MAX_STAGES];
   bit                         half_phase [HBD_MAX_STAGES];
   logic [CFG_W-1:0]           stage_count;

   // Q1.17 weights indexed by delay in samples.
   const int tap_weight [HBD_TAPS] = '{0, 0, 756, 0, -6386, 0, 38400, 65532,
                                       38400, 0, -6386, 0, 756, 0, 0};

   stereo_halfband_decimator_cascade #(
      .MAX_STAGES(HBD_MAX_STAGES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Round half away from zero, dropping the given number of fraction bits.
   function automatic longint round_away(input longint v, input int bits);
      longint half;
      half = longint'(1) <<< (bits - 1);
      if (v >= 0) begin
         return (v + half) >>> bits;
      end
      return -((-v + half) >>> bits);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Dot product of one stage's history with the half-band weights, brought
   // back to 8 fraction bits and held in the sample range.
   function automatic longint halfband_sum(input int ch, input int st, input int pos);
      longint acc;
      int     idx;
      acc = 0;
      for (int k = 0; k < HBD_TAPS; k++) begin
         idx = (pos + HBD_TAPS - k) % HBD_TAPS;
         acc += longint'(tap_weight[k]) * longint'(tap_line[ch][st][idx]);
      end
      return clip(round_away(acc, 17), -(longint'(1) <<< (SAMPLE_W - 1)),
                  (longint'(1) <<< (SAMPLE_W - 1)) - 1);
   endfunction

   // Runs one accepted frame through the stages in use and queues the
   // decimated frame if the last stage lets one through.
   function automatic void decimate_frame(input logic signed [PCM_W-1:0] l,
                                          input logic signed [PCM_W-1:0] r);
      longint       cur [2];
      longint       nxt [2];
      int           used;
      int           pos;
      bit           passing;
      pcm_pair_type out;
      cur[0]  = longint'(l) * 256;
      cur[1]  = longint'(r) * 256;
      used    = (stage_count > HBD_MAX_STAGES) ? HBD_MAX_STAGES : int'(stage_count);
      passing = 1'b1;
      for (int st = 0; st < used; st++) begin
         if (passing) begin
            pos = int'(head_pos[st]);
            for (int ch = 0; ch < 2; ch++) begin
               tap_line[ch][st][pos] = cur[ch][SAMPLE_W-1:0];
            end
            for (int ch = 0; ch < 2; ch++) begin
               nxt[ch] = halfband_sum(ch, st, pos);
            end
            head_pos[st]   = (pos == HBD_TAPS - 1) ? '0 : POS_W'(pos + 1);
            half_phase[st] = ~half_phase[st];
            // The stage only passes a value on every second sample.
            if (half_phase[st]) begin
               passing = 1'b0;
            end else begin
               cur = nxt;
            end
         end
      end
      if (passing) begin
         out.left  = PCM_W'(clip(round_away(cur[0], 8), -32768, 32767));
         out.right = PCM_W'(clip(round_away(cur[1], 8), -32768, 32767));
         decimated_q.push_back(out);
      end
   endfunction

   // Gap before a transfer: mostly none or short, now and then long.
   function automatic int pick_gap();
      int unsigned roll;
      if (!idle_on) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [PCM_W-1:0] gen_sample(input source_kind_type kind,
                                                          input int idx, input int amp,
                                                          input int per);
      logic signed [PCM_W-1:0] v;
      case (kind)
         SRC_NOISE: v = 16'($urandom);
         SRC_QUIET: v = 16'($urandom_range(0, 16) - 8);
         SRC_TONE:  v = ((idx / per) % 2) ? 16'(amp) : 16'(-amp);
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 16'sh7FFF;
               1:       v = 16'sh8000;
               2:       v = 16'sh0000;
               default: v = 16'shFFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   // Sends one stereo frame; returns at the edge of its transfer. The valid
   // stays high so that a frame with no gap follows without a bubble.
   task automatic push_frame(input logic signed [PCM_W-1:0] l,
                             input logic signed [PCM_W-1:0] r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decimate_frame(l, r);
   endtask

   // Waits until every expected frame is out and no frame is in flight.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (decimated_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_stage_count(input logic [CFG_W-1:0] n);
      csr_valid <= 1'b1;
      csr_data  <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      stage_count = n;
   endtask

   // With no stages every frame comes straight back.
   task automatic test_passthrough();
      settle_block();
      set_stage_count(2'd0);
      push_frame(16'sh7FFF, 16'sh8000);
      push_frame(16'sh8000, 16'sh7FFF);
      push_frame(16'sh0000, 16'sh0000);
      push_frame(16'shFFFF, 16'sh0001);
      push_frame(16'sh5555, 16'shAAAA);
   endtask

   // Alternating full-scale rails, of opposite sign on the two channels.
   task automatic test_one_stage();
      settle_block();
      set_stage_count(2'd1);
      for (int i = 0; i < 8; i++) begin
         push_frame((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 2) ? 16'sh7FFF : 16'sh8000);
      end
   endtask

   task automatic test_two_stages();
      settle_block();
      set_stage_count(2'd2);
      for (int i = 0; i < 8; i++) begin
         push_frame(((i / 2) % 2) ? 16'sh8000 : 16'sh7FFF, (i < 4) ? 16'sh7FFF : 16'sh0001);
      end
   endtask

   // A count above the number of stages acts as the full cascade.
   task automatic test_count_above_max();
      settle_block();
      set_stage_count(2'd3);
      push_frame(16'sh8000, 16'sh8000);
      push_frame(16'sh7FFF, 16'sh7FFF);
      push_frame(16'shFFFF, 16'sh0000);
      push_frame(16'sh0100, 16'shFF00);
   endtask

   // Phases of random streams; the count changes between phases without
   // clearing the filters, and some phases run with no idling at all.
   task automatic test_random_streams();
      source_kind_type         kind;
      int                      amp;
      int                      per;
      logic signed [PCM_W-1:0] l;
      logic signed [PCM_W-1:0] r;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_block();
         set_stage_count((ph < 4) ? CFG_W'(ph) : CFG_W'($urandom_range(0, 3)));
         kind    = source_kind_type'($urandom_range(0, 3));
         amp     = $urandom_range(0, 32767);
         per     = $urandom_range(1, 9);
         idle_on = (ph % 3 != 2);
         for (int i = 0; i < PHASE_FRAMES; i++) begin
            l = gen_sample(kind, i, amp, per);
            r = gen_sample(kind, i + per, amp, per);
            push_frame(l, r);
         end
      end
      idle_on = 1'b1;
   endtask

   // Output side: random stalls, and each transfer checked against the
   // oldest expected frame.
   int           rsp_hold = 0;
   pcm_pair_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decimated_q.size() == 0) begin
               $display("%0t: unexpected result transfer, got %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = decimated_q.pop_front();
               if ($signed(rsp_tdata[15:0]) !== want.left) begin
                  $display("%0t: left_out mismatch, expected %0d, got %0d", $time,
                           want.left, $signed(rsp_tdata[15:0]));
                  error_count++;
               end
               if ($signed(rsp_tdata[31:16]) !== want.right) begin
                  $display("%0t: right_out mismatch, expected %0d, got %0d", $time,
                           want.right, $signed(rsp_tdata[31:16]));
                  error_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_hold = pick_gap();
            rsp_tready <= (rsp_hold == 0);
         end
      end
   end

   initial begin
      for (int ch = 0; ch < 2; ch++) begin
         for (int st = 0; st < HBD_MAX_STAGES; st++) begin
            for (int k = 0; k < HBD_TAPS; k++) begin
               tap_line[ch][st][k] = '0;
            end
         end
      end
      for (int st = 0; st < HBD_MAX_STAGES; st++) begin
         head_pos[st]   = '0;
         half_phase[st] = 1'b0;
      end
      stage_count = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_one_stage();
      test_two_stages();
      test_count_above_max();
      test_random_streams();
      settle_block();
      if (error_count == 0 && decimated_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
src/hbd_pkg.sv
src/hbd_ram.sv
src/hbd_lane.sv
src/hbd_merge.sv
src/stereo_halfband_decimator_cascade.sv
tb/sv/tb.sv
